[sv/lucov_pkg.sv]
// Shared constants for the lattice upper-cover block.
// Field widths of the item ports and the reset value of the size register.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lucov_pkg;

    // Fixed widths of the request and result fields.
    localparam int MEET_W    = 4;
    localparam int SIZE_W    = 5;
    localparam int ELEMENT_W = 4;
    localparam int MASK_W    = 16;

    // The size register comes out of reset selecting a sixteen element lattice.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

endpackage

`default_nettype wire

[sv/lucov_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the order relation rows.
`timescale 1ns / 1ps
`default_nettype none

module lucov_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/lucov_fifo.sv]
// Short queue that carries finished relation rows from the front to the back.
// Depends on nothing; payload width and depth are parameters.
`timescale 1ns / 1ps
`default_nettype none

module lucov_fifo #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

`ifndef NO_ASSERTIONS
    // The front holds its final entry of a row back while the queue is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("row pushed into a full queue");
`endif

endmodule

`default_nettype wire

[sv/lucov_front.sv]
// Load front: takes meet table entries, classifies each as below or not,
// and assembles one relation row at a time for the queue. Uses lucov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lucov_front
    import lucov_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]     i_n,
    input  wire logic                                  i_restart,
    input  wire logic                                  i_in_valid,
    input  wire logic [MEET_W-1:0]                     i_meet_value,
    output logic                                       o_in_stall,
    output logic                                       o_push,
    output logic [$clog2(MAX_ELEMENTS)+MAX_ELEMENTS:0] o_push_data,
    input  wire logic                                  i_q_full
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int NW = $clog2(MAX_ELEMENTS + 1);

    logic [NW-1:0]           r_row;
    logic [NW-1:0]           r_col;
    logic [MAX_ELEMENTS-1:0] r_acc, n_acc;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          is_below;
    logic [IW-1:0] row_idx;
    logic [IW-1:0] col_idx;

    assign row_idx  = r_row[IW-1:0];
    assign col_idx  = r_col[IW-1:0];
    assign last_col = (r_col == i_n - NW'(1));
    assign last_row = (r_row == i_n - NW'(1));

    // Only the entry that closes a row needs room in the queue.
    assign o_in_stall = last_col && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_below = ({{IW{1'b0}}, i_meet_value} == {{MEET_W{1'b0}}, row_idx})
                      && (r_row != r_col);

    always_comb begin
        n_acc = (r_col == '0) ? '0 : r_acc;
        n_acc = n_acc | ({{(MAX_ELEMENTS-1){1'b0}}, is_below} << col_idx);
    end

    assign o_push      = accept && last_col;
    assign o_push_data = {row_idx, last_row, n_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

[sv/lucov_back.sv]
// Cover back end: writes relation rows into the row RAM and, once a table is
// complete, scans the rows to find each element's upper covers.
// Uses lucov_pkg and lucov_ram.
`timescale 1ns / 1ps
`default_nettype none

module lucov_back
    import lucov_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]     i_n,
    input  wire logic [$clog2(MAX_ELEMENTS)+MAX_ELEMENTS:0] i_q_data,
    input  wire logic                                  i_q_empty,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [ELEMENT_W-1:0]                       o_element,
    output logic [MASK_W-1:0]                          o_cover_mask,
    output logic                                       o_last_row
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int NW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RDI  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_back_state;

    t_back_state r_state, n_state;

    logic [IW-1:0]           r_i, n_i;
    logic [NW-1:0]           r_issue, n_issue;
    logic                    r_pend, n_pend;
    logic [IW-1:0]           r_pk, n_pk;
    logic [MAX_ELEMENTS-1:0] r_ri, n_ri;
    logic [MAX_ELEMENTS-1:0] r_acc, n_acc;
    logic [MAX_ELEMENTS-1:0] r_cov, n_cov;
    logic                    r_ovalid, n_ovalid;
    logic [ELEMENT_W-1:0]    r_oelem;
    logic [MASK_W-1:0]       r_omask;
    logic                    r_olast;

    logic [IW-1:0]           q_row;
    logic                    q_last;
    logic [MAX_ELEMENTS-1:0] q_bits;
    logic [IW-1:0]           raddr;
    logic [MAX_ELEMENTS-1:0] rdata;
    logic [MAX_ELEMENTS-1:0] hit_data;
    logic                    out_free;
    logic                    out_take;
    logic                    out_load;
    logic                    elem_is_last;
    logic [IW+ELEMENT_W-1:0] elem_ext;
    logic [MAX_ELEMENTS+MASK_W-1:0] mask_ext;

    assign {q_row, q_last, q_bits} = i_q_data;

    assign o_pop        = (r_state == S_IDLE) && !i_q_empty;
    assign out_take     = r_ovalid && !i_out_stall;
    assign out_free     = !r_ovalid || !i_out_stall;
    assign out_load     = (r_state == S_EMIT) && out_free;
    assign elem_is_last = ({{(NW-IW){1'b0}}, r_i} == i_n - NW'(1));
    assign hit_data     = (r_pend && r_ri[r_pk]) ? rdata : '0;

    assign raddr = (r_state == S_SCAN) ? r_issue[IW-1:0] : r_i;

    lucov_ram #(
        .WIDTH (MAX_ELEMENTS),
        .DEPTH (MAX_ELEMENTS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (q_row),
        .i_wdata (q_bits),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_issue = r_issue;
        n_pend  = r_pend;
        n_pk    = r_pk;
        n_ri    = r_ri;
        n_acc   = r_acc;
        n_cov   = r_cov;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && q_last) begin
                    n_i     = '0;
                    n_state = S_RDI;
                end
            end
            S_RDI: begin
                n_issue = '0;
                n_pend  = 1'b0;
                n_acc   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // The first cycle returns row i itself; later ones return row k.
                if (!r_pend) begin
                    n_ri = rdata;
                end else begin
                    n_acc = r_acc | hit_data;
                end
                if (r_issue < i_n) begin
                    n_pend  = 1'b1;
                    n_pk    = r_issue[IW-1:0];
                    n_issue = r_issue + 1'b1;
                end else begin
                    n_cov   = r_ri & ~(r_acc | hit_data);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (elem_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_RDI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (out_take) begin
            n_ovalid = 1'b0;
        end
    end

    assign elem_ext = {{ELEMENT_W{1'b0}}, r_i};
    assign mask_ext = {{MASK_W{1'b0}}, r_cov};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_issue  <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_i      <= n_i;
            r_issue  <= n_issue;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pk  <= n_pk;
        r_ri  <= n_ri;
        r_acc <= n_acc;
        r_cov <= n_cov;
        if (out_load) begin
            r_oelem <= elem_ext[ELEMENT_W-1:0];
            r_omask <= mask_ext[MASK_W-1:0];
            r_olast <= elem_is_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_element    = r_oelem;
    assign o_cover_mask = r_omask;
    assign o_last_row   = r_olast;

`ifndef NO_ASSERTIONS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= i_n))
        else $error("row scan ran past the lattice size");

    a_pend_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_pend) |-> ({{(NW-IW){1'b0}}, r_pk} < i_n))
        else $error("returned row index outside the lattice");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && elem_is_last) |=> ((r_state == S_IDLE) && r_ovalid && r_olast))
        else $error("final cover result did not end the table");
`endif

endmodule

`default_nettype wire

[sv/lattice_upper_covers.sv]
// Top level of the lattice upper-cover block: size register, load front,
// row queue and cover back end. Uses lucov_pkg, lucov_front, lucov_fifo, lucov_back.
//
// Usage. The input channel (i_in_valid, o_in_stall, i_meet_value) takes the
// meet table of an n element lattice, one entry per request, row by row.
// Each entry is classified at once and one entry is taken every cycle; the
// front stalls only on the entry that closes a row while the two-row queue
// to the back end is full. After the last entry of a table the back end finds
// the upper covers of every element. For each element it reads its own row
// and then each of the n table rows through its single read port. The next
// table loads while covers are still being computed, up to the queue depth.
// The output channel (o_out_valid, i_out_stall, o_element, o_cover_mask,
// o_last_row) is driven from a result register; while the receiver stalls,
// the result holds and the back end waits, the front keeps loading.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_lattice_size)
// is always ready; a write sets the size and restarts loading at the first
// entry. A size of zero acts as one, one above MAX_ELEMENTS as MAX_ELEMENTS.
// Reset empties the queue and result register, restarts loading and selects
// a sixteen element lattice. Row contents are not cleared; every row is
// written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module lattice_upper_covers
    import lucov_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SIZE_W-1:0]    i_cfg_lattice_size,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [MEET_W-1:0]    i_meet_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [ELEMENT_W-1:0]      o_element,
    output logic [MASK_W-1:0]         o_cover_mask,
    output logic                      o_last_row
);

    localparam int IW      = $clog2(MAX_ELEMENTS);
    localparam int NW      = $clog2(MAX_ELEMENTS + 1);
    localparam int QW      = IW + 1 + MAX_ELEMENTS;
    localparam int Q_DEPTH = 2;

    logic [SIZE_W-1:0]    r_size;
    logic [NW+SIZE_W-1:0] size_ext;
    logic [NW-1:0]        size_in_use;
    logic                 cfg_write;

    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_pop;
    logic [QW-1:0] q_rdata;
    logic          q_full;
    logic          q_empty;

    // The configuration port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (cfg_write) begin
            r_size <= i_cfg_lattice_size;
        end
    end

    // Clamp the written size into the range that the row storage supports.
    assign size_ext = {{NW{1'b0}}, r_size};

    always_comb begin
        if (r_size == '0) begin
            size_in_use = NW'(1);
        end else if (size_ext > (NW+SIZE_W)'(MAX_ELEMENTS)) begin
            size_in_use = NW'(MAX_ELEMENTS);
        end else begin
            size_in_use = size_ext[NW-1:0];
        end
    end

    lucov_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (size_in_use),
        .i_restart    (cfg_write),
        .i_in_valid   (i_in_valid),
        .i_meet_value (i_meet_value),
        .o_in_stall   (o_in_stall),
        .o_push       (q_push),
        .o_push_data  (q_wdata),
        .i_q_full     (q_full)
    );

    lucov_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lucov_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n          (size_in_use),
        .i_q_data     (q_rdata),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_element    (o_element),
        .o_cover_mask (o_cover_mask),
        .o_last_row   (o_last_row)
    );

endmodule

`default_nettype wire

[test/lattice_upper_covers_tb.sv]
// Self-checking testbench for lattice_upper_covers: sends meet tables and checks
// every upper-cover result against a predictor kept inside the bench.
// Depends on lucov_pkg and the lattice_upper_covers RTL.
`timescale 1ns / 1ps

module lattice_upper_covers_tb;
    import lucov_pkg::*;

    localparam int MAX_ELEMENTS = 16;
    // One full cover pass plus margin; used before size writes and at the end.
    localparam int SETTLE_CYCLES = MAX_ELEMENTS * (MAX_ELEMENTS + 3) + 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 80;
    localparam int IDLE_PERCENT = 7;

    // One expected result: the lower element, its cover mask and the end flag.
    typedef struct {
        logic [ELEMENT_W-1:0] element;
        logic [MASK_W-1:0]    cover_mask;
        logic                 last_row;
    } t_cover_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [SIZE_W-1:0]    cfg_size = '0;
    logic                 in_valid = 1'b0;
    logic [MEET_W-1:0]    meet_value = '0;
    logic                 out_stall = 1'b0;
    wire                  cfg_ready;
    wire                  in_stall;
    wire                  out_valid;
    wire [ELEMENT_W-1:0]  element;
    wire [MASK_W-1:0]     cover_mask;
    wire                  last_row;

    // Predictor state: the strict order relation, the load position and the
    // size register, all updated as requests and writes are accepted.
    t_cover_row           covers_due[$];
    logic [MAX_ELEMENTS-1:0] order_rows [MAX_ELEMENTS];
    int                   next_row = 0;
    int                   next_col = 0;
    logic [SIZE_W-1:0]    size_reg = SIZE_RESET;

    // The table that the next send_table call delivers, row by row.
    logic [MEET_W-1:0]    meet_table [MAX_ELEMENTS][MAX_ELEMENTS];

    // While calm is set neither side idles, giving long gap-free stretches.
    bit                   calm = 1'b0;
    int                   errors = 0;
    int                   cycles = 0;
    int                   sent_items = 0;

    lattice_upper_covers #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_lattice_size(cfg_size),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_meet_value      (meet_value),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_element         (element),
        .o_cover_mask      (cover_mask),
        .o_last_row        (last_row)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver stalls now and then, independent of whether a result is
    // offered, so stalls land on every phase of the cover pass.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // A size of zero behaves as one; anything above the built maximum as the maximum.
    function automatic int size_used();
        if (size_reg == 0)
            return 1;
        if (size_reg > MAX_ELEMENTS)
            return MAX_ELEMENTS;
        return int'(size_reg);
    endfunction

    // Element upper covers lower when lower is below it and nothing sits between.
    function automatic logic [MASK_W-1:0] expected_covers(input int lower, input int n);
        logic [MASK_W-1:0] mask;
        bit                between;
        int                upper;
        int                mid;
        mask = '0;
        for (upper = 0; upper < n; upper++) begin
            if (order_rows[lower][upper]) begin
                between = 1'b0;
                for (mid = 0; mid < n; mid++) begin
                    if (order_rows[lower][mid] && order_rows[mid][upper])
                        between = 1'b1;
                end
                if (!between)
                    mask[upper] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Applies one accepted table entry. The entry that closes the table queues
    // one result per element, lowest element first.
    task automatic record_meet(input logic [MEET_W-1:0] v);
        int         n;
        int         lower;
        t_cover_row row;
        n = size_used();
        if (next_row >= n)
            next_row = 0;
        if (next_col >= n)
            next_col = 0;
        order_rows[next_row][next_col] = (int'(v) == next_row) && (next_row != next_col);
        next_col++;
        if (next_col == n) begin
            next_col = 0;
            next_row++;
            if (next_row == n) begin
                next_row = 0;
                for (lower = 0; lower < n; lower++) begin
                    row.element    = ELEMENT_W'(lower);
                    row.cover_mask = expected_covers(lower, n);
                    row.last_row   = (lower == n - 1);
                    covers_due.push_back(row);
                end
            end
        end
    endtask

    // Sends one request. Valid may drop for random idle cycles before it, but
    // once raised it stays high with a fixed payload until accepted.
    task automatic send_meet(input logic [MEET_W-1:0] v);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        meet_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        record_meet(v);
        sent_items++;
    endtask

    // Holds the sender back until every queued result has come out.
    task automatic drain_covers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (covers_due.size() != 0)
            @(posedge clk);
    endtask

    // Size writes happen only with the block idle. A partial table leaves no
    // result to wait for, so a full cover pass worth of cycles passes first.
    task automatic write_size(input logic [SIZE_W-1:0] w);
        drain_covers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_size  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg  = w;
        next_row  = 0;
        next_col  = 0;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_table(input int n);
        int r;
        int c;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++)
                send_meet(meet_table[r][c]);
        end
    endtask

    // Closes a family of 4-bit sets under intersection. Bit m of the family
    // says that set m is a member.
    function automatic logic [15:0] meet_closure(input logic [15:0] family);
        logic [15:0] grown;
        int          a;
        int          b;
        grown = family;
        do begin
            family = grown;
            for (a = 0; a < 16; a++) begin
                for (b = 0; b < 16; b++) begin
                    if (family[a] && family[b])
                        grown[a & b] = 1'b1;
                end
            end
        end while (grown != family);
        return grown;
    endfunction

    // Builds a random lattice as a family of subsets of a 4-bit universe that
    // holds the full set and is closed under intersection, so the meet is the
    // intersection. Elements get shuffled indexes. The size reached may fall
    // short of the target; n returns it.
    task automatic build_lattice(input int target, output int n);
        logic [15:0]       family;
        logic [15:0]       grown;
        logic [MEET_W-1:0] masks [16];
        logic [MEET_W-1:0] slot [16];
        logic [MEET_W-1:0] swap;
        int                tries;
        int                a;
        int                b;
        family = 16'h8000;
        if (target >= 16)
            family = 16'hFFFF;
        for (tries = 0; tries < 200 && $countones(family) < target; tries++) begin
            grown = meet_closure(family | (16'h1 << $urandom_range(15)));
            if ($countones(grown) <= target)
                family = grown;
        end
        n = 0;
        for (a = 0; a < 16; a++) begin
            if (family[a]) begin
                masks[n] = a[3:0];
                n++;
            end
        end
        for (a = n - 1; a > 0; a--) begin
            b        = $urandom_range(a);
            swap     = masks[a];
            masks[a] = masks[b];
            masks[b] = swap;
        end
        for (a = 0; a < n; a++)
            slot[masks[a]] = a[3:0];
        for (a = 0; a < n; a++) begin
            for (b = 0; b < n; b++)
                meet_table[a][b] = slot[masks[a] & masks[b]];
        end
    endtask

    // Fills an n by n table with arbitrary values over the whole field range.
    task automatic scramble_table(input int n);
        int a;
        int b;
        for (a = 0; a < n; a++) begin
            for (b = 0; b < n; b++)
                meet_table[a][b] = MEET_W'($urandom_range(15));
        end
    endtask

    // A full sixteen element lattice loaded with the size left at its reset
    // value. This one runs with no idling on either side.
    task automatic test_reset_size();
        int n;
        calm = 1'b1;
        build_lattice(MAX_ELEMENTS, n);
        send_table(n);
        calm = 1'b0;
    endtask

    // Size zero acts as one: a single entry closes the table and gives one
    // result with an empty mask. Then the same with an explicit size of one.
    task automatic test_smallest_size();
        write_size(5'd0);
        send_meet(4'hF);
        write_size(5'd1);
        send_meet(4'h0);
    endtask

    // Two-element chain with zero at the bottom.
    task automatic test_two_chain();
        write_size(5'd2);
        send_meet(4'h0);
        send_meet(4'h0);
        send_meet(4'h0);
        send_meet(4'h1);
    endtask

    // A table that is no lattice: an out-of-range meet and a cycle between
    // elements one and two. Covers are still computed from the raw relation.
    task automatic test_not_a_lattice();
        logic [MEET_W-1:0] entries [9] = '{4'h0, 4'h0, 4'h0, 4'hF, 4'h1, 4'h1,
                                           4'h8, 4'h2, 4'h2};
        int                k;
        write_size(5'd3);
        for (k = 0; k < 9; k++)
            send_meet(entries[k]);
    endtask

    // A size write in the middle of a load throws the partial table away and
    // the next table starts again at the first entry.
    task automatic test_restart_on_write();
        int k;
        write_size(5'd3);
        for (k = 0; k < 4; k++)
            send_meet(MEET_W'($urandom_range(15)));
        write_size(5'd2);
        send_meet(4'h0);
        send_meet(4'h1);
        send_meet(4'h1);
        send_meet(4'h1);
    endtask

    // The largest size code behaves as the built maximum: a row and a half of
    // a sixteen element table closes nothing, and the size write that comes
    // next throws the partial load away.
    task automatic test_oversize();
        int k;
        write_size(5'd31);
        for (k = 0; k < MAX_ELEMENTS + MAX_ELEMENTS / 2; k++)
            send_meet(MEET_W'($urandom_range(15)));
    endtask

    // Mostly random lattices of small size, some arbitrary tables, and some
    // loads cut short by a size write. Tables of equal size run back to back
    // so the next load overlaps the cover pass of the last one.
    task automatic test_random_tables();
        int                first;
        int                n;
        int                kind;
        int                cut;
        int                k;
        bit                rewrite;
        logic [SIZE_W-1:0] code;
        first   = sent_items;
        rewrite = 1'b0;
        while (sent_items - first < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            calm = ($urandom_range(5) == 0);
            if (kind < 15) begin
                n = $urandom_range(1, 6);
                scramble_table(n);
            end else begin
                build_lattice(($urandom_range(9) == 0) ? $urandom_range(8, 12)
                                                       : $urandom_range(2, 7), n);
            end
            code = SIZE_W'(n);
            if (n == 1 && $urandom_range(1) == 0)
                code = '0;
            if (rewrite || n != size_used() || $urandom_range(7) == 0)
                write_size(code);
            else if ($urandom_range(4) == 0)
                drain_covers();
            rewrite = 1'b0;
            if (kind >= 88 && n > 1) begin
                cut = $urandom_range(1, n * n - 1);
                for (k = 0; k < cut; k++)
                    send_meet(meet_table[k / n][k % n]);
                rewrite = 1'b1;
            end else begin
                send_table(n);
            end
        end
        calm = 1'b0;
    endtask

    // Every accepted result is matched against the oldest expected one.
    always @(posedge clk) begin : check_result
        t_cover_row want;
        if (rst_n && out_valid && !out_stall) begin
            if (covers_due.size() == 0) begin
                report_mismatch($sformatf("result for element %0d with none expected",
                                          element));
            end else begin
                want = covers_due.pop_front();
                if (element !== want.element)
                    report_mismatch($sformatf("element %0d, expected %0d",
                                              element, want.element));
                if (cover_mask !== want.cover_mask)
                    report_mismatch($sformatf("element %0d cover mask %h, expected %h",
                                              want.element, cover_mask, want.cover_mask));
                if (last_row !== want.last_row)
                    report_mismatch($sformatf("element %0d last row %b, expected %b",
                                              want.element, last_row, want.last_row));
            end
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_size();
        test_smallest_size();
        test_two_chain();
        test_not_a_lattice();
        test_restart_on_write();
        test_oversize();
        test_random_tables();
        drain_covers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && covers_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
